>>> hdl/tdpe_pkg.sv
// shared types and constants of the two-dimensional parity encoder
package tdpe_pkg;

   // fixed field widths of the channels and registers
   localparam int DATA_W     = 32;
   localparam int ROWS_REG_W = 9;
   localparam int COLS_REG_W = 6;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;

   // parameter defaults
   localparam int COLS_MAX_DEF  = 32;
   localparam int ROWS_MAX_DEF  = 256;
   localparam int WORD_BITS_DEF = 32;

   // register reset values
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(8);
   localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(8);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_reg_type;

   // kind of word on the result channel
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_ROW  = 2'd1,
      KIND_COL  = 2'd2,
      KIND_ALL  = 2'd3
   } word_kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_DATA,
      ST_ROW,
      ST_COL,
      ST_ALL
   } state_type;

   // control shared by every column cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

>>> hdl/tdpe_if.sv
// request and response channel interfaces of the parity encoder

// data word channel
interface tdpe_req_if;
   import tdpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_word;

   modport source (output valid, output data_word, input ready);
   modport sink   (input valid, input data_word, output ready);
endinterface

// result word channel
interface tdpe_rsp_if;
   import tdpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_word;
   word_kind_type     word_kind;
   logic              last_of_run;

   modport source (output valid, output out_word, output word_kind, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_word, input word_kind, input last_of_run,
                   output ready);
endinterface

>>> hdl/tdpe_cell.sv
// one column parity cell of the rotating column chain
module tdpe_cell #(
   parameter int WORD_BITS  = tdpe_pkg::WORD_BITS_DEF,
   parameter int COL_IDX_W  = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                     clock,
   input  tdpe_pkg::cell_ctl_type   ctl,
   input  logic [COL_IDX_W-1:0]     cols_last,
   input  logic [WORD_BITS-1:0]     tail_in,
   input  logic [WORD_BITS-1:0]     next_in,
   output logic [WORD_BITS-1:0]     word_out
);
   import tdpe_pkg::*;

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 is_tail;

   // the cell at the last column in use takes the updated head word
   assign is_tail = (cols_last == COL_IDX_W'(CELL_INDEX));

   // next value: clear, rotate toward the head, or hold
   always_comb begin
      if (ctl.clear) begin
         word_in = '0;
      end else if (ctl.shift) begin
         word_in = is_tail ? tail_in : next_in;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

>>> hdl/two_d_parity_encoder.sv
// top level of the two-dimensional parity encoder with its column cell chain
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    data_word
//  rsp      out  valid / ready    out_word, word_kind, last_of_run
//  csr      in   csr_we           csr_index, csr_wdata
//
// data words pass through; the last word of a row adds the row parity, and the last
// word of a block also adds the column drain and the overall parity. the chain head
// drains one word per cycle while the single output register is free.
// reset is synchronous and clears the sequencer, accumulators and every column cell.
// rsp.ready low holds the output register and req.ready drops until it is taken.
module two_d_parity_encoder #(
   parameter int COLS_MAX  = tdpe_pkg::COLS_MAX_DEF,
   parameter int ROWS_MAX  = tdpe_pkg::ROWS_MAX_DEF,
   parameter int WORD_BITS = tdpe_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   tdpe_req_if.sink                           req,
   tdpe_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [tdpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdpe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tdpe_pkg::*;

   localparam int COL_IDX_W = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
   localparam int ROW_IDX_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;

   // configuration registers
   logic [ROWS_REG_W-1:0] rows_ff, rows_in;
   logic [COLS_REG_W-1:0] cols_ff, cols_in;
   logic [ROW_IDX_W-1:0]  rows_last;
   logic [COL_IDX_W-1:0]  cols_last;

   // sequencer and accumulators
   state_type             state_ff, state_in;
   logic [ROW_IDX_W-1:0]  row_idx_ff, row_idx_in;
   logic [COL_IDX_W-1:0]  col_idx_ff, col_idx_in;
   logic [COL_IDX_W-1:0]  drain_ff, drain_in;
   logic [WORD_BITS-1:0]  row_acc_ff, row_acc_in;
   logic [WORD_BITS-1:0]  corner_ff, corner_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_word_ff, rsp_word_in;
   word_kind_type         rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   // column chain
   logic [WORD_BITS-1:0]  cell_word [COLS_MAX];
   logic [WORD_BITS-1:0]  tail_word;
   cell_ctl_type          cell_ctl;

   logic [WORD_BITS-1:0]  w;
   logic                  slot_free;
   logic                  load;

   // configuration write
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_ROWS: rows_in = csr_wdata[ROWS_REG_W-1:0];
            CSR_COLS: cols_in = csr_wdata[COLS_REG_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // last row and column in use, zero acting as one and clamped to the maximum
   always_comb begin
      if (rows_ff == '0) begin
         rows_last = '0;
      end else if (32'(rows_ff) > 32'(ROWS_MAX)) begin
         rows_last = ROW_IDX_W'(ROWS_MAX - 1);
      end else begin
         rows_last = ROW_IDX_W'(rows_ff - 1'b1);
      end
      if (cols_ff == '0) begin
         cols_last = '0;
      end else if (32'(cols_ff) > 32'(COLS_MAX)) begin
         cols_last = COL_IDX_W'(COLS_MAX - 1);
      end else begin
         cols_last = COL_IDX_W'(cols_ff - 1'b1);
      end
   end

   assign w         = WORD_BITS'(req.data_word);
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // sequencer: next state, accumulators and output loads
   always_comb begin
      state_in       = state_ff;
      row_idx_in     = row_idx_ff;
      col_idx_in     = col_idx_ff;
      drain_in       = drain_ff;
      row_acc_in     = row_acc_ff;
      corner_in      = corner_ff;
      load           = 1'b0;
      rsp_word_in    = rsp_word_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      tail_word      = cell_word[0] ^ w;
      cell_ctl.shift = 1'b0;
      cell_ctl.clear = reset || csr_we;
      req.ready      = 1'b0;

      unique case (state_ff)
         ST_DATA: begin
            req.ready = slot_free;
            if (req.valid && slot_free) begin
               load           = 1'b1;
               rsp_word_in    = DATA_W'(w);
               rsp_kind_in    = KIND_DATA;
               rsp_last_in    = (col_idx_ff != cols_last);
               row_acc_in     = row_acc_ff ^ w;
               corner_in      = corner_ff ^ w;
               cell_ctl.shift = 1'b1;
               if (col_idx_ff == cols_last) begin
                  col_idx_in = '0;
                  state_in   = ST_ROW;
               end else begin
                  col_idx_in = col_idx_ff + 1'b1;
               end
            end
         end
         ST_ROW: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_word_in = DATA_W'(row_acc_ff);
               rsp_kind_in = KIND_ROW;
               rsp_last_in = (row_idx_ff != rows_last);
               row_acc_in  = '0;
               if (row_idx_ff == rows_last) begin
                  row_idx_in = '0;
                  drain_in   = '0;
                  state_in   = ST_COL;
               end else begin
                  row_idx_in = row_idx_ff + 1'b1;
                  state_in   = ST_DATA;
               end
            end
         end
         ST_COL: begin
            // drain the head cell and refill the chain with zeros
            tail_word = '0;
            if (slot_free) begin
               load           = 1'b1;
               rsp_word_in    = DATA_W'(cell_word[0]);
               rsp_kind_in    = KIND_COL;
               rsp_last_in    = 1'b0;
               cell_ctl.shift = 1'b1;
               if (drain_ff == cols_last) begin
                  state_in = ST_ALL;
               end else begin
                  drain_in = drain_ff + 1'b1;
               end
            end
         end
         ST_ALL: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_word_in = DATA_W'(corner_ff);
               rsp_kind_in = KIND_ALL;
               rsp_last_in = 1'b1;
               corner_in   = '0;
               state_in    = ST_DATA;
            end
         end
         default: state_in = ST_DATA;
      endcase

      // any register write abandons the block in progress
      if (csr_we) begin
         state_in   = ST_DATA;
         row_idx_in = '0;
         col_idx_in = '0;
         drain_in   = '0;
         row_acc_in = '0;
         corner_in  = '0;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DATA;
         row_idx_ff   <= '0;
         col_idx_ff   <= '0;
         drain_ff     <= '0;
         row_acc_ff   <= '0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_idx_ff   <= row_idx_in;
         col_idx_ff   <= col_idx_in;
         drain_ff     <= drain_in;
         row_acc_ff   <= row_acc_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_word    = rsp_word_ff;
   assign rsp.word_kind   = rsp_kind_ff;
   assign rsp.last_of_run = rsp_last_ff;

   // column chain: cell 0 is the head, words rotate one cell toward it per shift
   for (genvar i = 0; i < COLS_MAX; i++) begin : g_cell
      logic [WORD_BITS-1:0] next_word;
      if (i == COLS_MAX - 1) begin : g_end
         assign next_word = '0;
      end else begin : g_mid
         assign next_word = cell_word[i+1];
      end
      tdpe_cell #(
         .WORD_BITS  (WORD_BITS),
         .COL_IDX_W  (COL_IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .cols_last (cols_last),
         .tail_in   (tail_word),
         .next_in   (next_word),
         .word_out  (cell_word[i])
      );
   end

   // data words are taken only while the sequencer is in the data state
   a_req_in_data: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |-> state_ff == ST_DATA)
      else $error("data transaction accepted outside the data state");

   // the overall parity word always closes its run
   a_all_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ALL |-> rsp_last_ff)
      else $error("overall parity word without last_of_run");

   // indexes stay within the block size in use
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_idx_ff <= cols_last)
      else $error("column index beyond last column");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_idx_ff <= rows_last)
      else $error("row index beyond last row");

   // the column drain never runs past the last column
   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COL |-> drain_ff <= cols_last)
      else $error("column drain beyond last column");

endmodule

>>> tb/sv/two_d_parity_encoder_test.sv
// self-checking testbench of the two-dimensional parity encoder with random handshakes
module two_d_parity_encoder_test;
   import tdpe_pkg::*;

   localparam int PERIOD         = 20;
   localparam int COLS_MAX       = COLS_MAX_DEF;
   localparam int ROWS_MAX       = ROWS_MAX_DEF;
   localparam int RANDOM_WORDS   = 430;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = COLS_MAX + 8;

   // one word of the coded stream as it should leave the block
   typedef struct packed {
      logic [DATA_W-1:0] word;
      word_kind_type     kind;
      logic              last_flag;
   } coded_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tdpe_req_if req_ch ();
   tdpe_rsp_if rsp_ch ();

   two_d_parity_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // encoder state as predicted by the testbench
   logic [ROWS_REG_W-1:0] rows_reg;
   logic [COLS_REG_W-1:0] cols_reg;
   logic [DATA_W-1:0]     row_acc;
   logic [DATA_W-1:0]     corner_acc;
   logic [DATA_W-1:0]     col_parity [COLS_MAX];
   int unsigned           row_pos;
   int unsigned           col_pos;

   logic [DATA_W-1:0] words_to_send [$];
   coded_word_type    due_words [$];

   int unsigned fail_count;
   int unsigned words_sent;
   int unsigned words_checked;
   int unsigned settings_used;
   int unsigned kind_seen [4];
   int unsigned stall_cycles;

   int unsigned send_pause;
   int unsigned send_stretch;
   bit          send_calm;
   int unsigned take_pause;
   int unsigned take_stretch;
   bit          take_calm;

   always #(PERIOD / 2) clock = ~clock;

   function automatic int unsigned eff_rows();
      int unsigned r;
      r = rows_reg;
      if (r == 0) r = 1;
      if (r > ROWS_MAX) r = ROWS_MAX;
      return r;
   endfunction

   function automatic int unsigned eff_cols();
      int unsigned c;
      c = cols_reg;
      if (c == 0) c = 1;
      if (c > COLS_MAX) c = COLS_MAX;
      return c;
   endfunction

   function automatic void clear_block();
      row_acc    = '0;
      corner_acc = '0;
      foreach (col_parity[k]) col_parity[k] = '0;
      row_pos    = 0;
      col_pos    = 0;
   endfunction

   // pass-through word, then row parity, column parities and overall parity as due
   function automatic void encode_word(input logic [DATA_W-1:0] w);
      int unsigned nrows;
      int unsigned ncols;
      coded_word_type run [$];
      nrows = eff_rows();
      ncols = eff_cols();
      if (col_pos >= ncols) col_pos = ncols - 1;
      if (row_pos >= nrows) row_pos = nrows - 1;
      run.push_back('{w, KIND_DATA, 1'b0});
      row_acc             ^= w;
      corner_acc          ^= w;
      col_parity[col_pos] ^= w;
      if (col_pos + 1 >= ncols) begin
         run.push_back('{row_acc, KIND_ROW, 1'b0});
         row_acc = '0;
         col_pos = 0;
         if (row_pos + 1 >= nrows) begin
            for (int k = 0; k < ncols; k++) run.push_back('{col_parity[k], KIND_COL, 1'b0});
            run.push_back('{corner_acc, KIND_ALL, 1'b0});
            clear_block();
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      run[run.size() - 1].last_flag = 1'b1;
      foreach (run[k]) due_words.push_back(run[k]);
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("mismatch at %0t: %s", $time, what);
   endfunction

   // mostly no pause, some short ones, a few long ones
   function automatic int unsigned draw_pause(input bit calm);
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // size register write; any write abandons the block in progress
   task automatic write_size(input csr_reg_type idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ROWS) rows_reg = ROWS_REG_W'(value);
      else cols_reg = COLS_REG_W'(value);
      clear_block();
   endtask

   // wait until every word is sent and every expected word has come back
   task automatic wait_idle();
      while (words_to_send.size() != 0 || req_ch.valid || due_words.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            encode_word(req_ch.data_word);
            words_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_ch.valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               req_ch.valid     <= 1'b1;
               req_ch.data_word <= words_to_send.pop_front();
               if (send_stretch == 0) begin
                  send_calm    = ($urandom_range(0, 2) == 0);
                  send_stretch = $urandom_range(10, 60);
               end
               send_stretch--;
               send_pause = draw_pause(send_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      coded_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_words.size() == 0) begin
               note_failure($sformatf("unexpected word %h kind %0d last %b",
                  rsp_ch.out_word, rsp_ch.word_kind, rsp_ch.last_of_run));
            end else begin
               want = due_words.pop_front();
               words_checked++;
               kind_seen[want.kind]++;
               if (rsp_ch.out_word !== want.word)
                  note_failure($sformatf("out_word expected %h got %h (kind %0d)",
                     want.word, rsp_ch.out_word, want.kind));
               if (rsp_ch.word_kind !== want.kind)
                  note_failure($sformatf("word_kind expected %0d got %0d",
                     want.kind, rsp_ch.word_kind));
               if (rsp_ch.last_of_run !== want.last_flag)
                  note_failure($sformatf("last_of_run expected %b got %b (kind %0d)",
                     want.last_flag, rsp_ch.last_of_run, want.kind));
            end
         end
         if (take_pause > 0) begin
            take_pause--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (take_stretch == 0) begin
               take_calm    = ($urandom_range(0, 2) == 0);
               take_stretch = $urandom_range(10, 60);
            end
            take_stretch--;
            take_pause = draw_pause(take_calm);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d words still expected",
            stall_cycles, due_words.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      int unsigned random_words;
      int unsigned phase_no;
      int unsigned rows_val;
      int unsigned cols_val;
      int unsigned block;
      int unsigned count;

      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_ROWS;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_word = '0;
      rsp_ch.ready     = 1'b0;
      rows_reg         = ROWS_RESET;
      cols_reg         = COLS_RESET;
      clear_block();
      fail_count       = 0;
      words_sent       = 0;
      words_checked    = 0;
      settings_used    = 1;
      kind_seen        = '{default: 0};
      send_pause       = 0;
      send_stretch     = 0;
      send_calm        = 1'b0;
      take_pause       = 0;
      take_stretch     = 0;
      take_calm        = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: one full row of extreme and walking patterns
      words_to_send.push_back('0);
      words_to_send.push_back('1);
      words_to_send.push_back(DATA_W'(1));
      words_to_send.push_back(DATA_W'(1) << (DATA_W - 1));
      words_to_send.push_back({(DATA_W / 2){2'b10}});
      words_to_send.push_back({(DATA_W / 2){2'b01}});
      words_to_send.push_back(random_word());
      words_to_send.push_back('1);
      wait_idle();

      // zero sizes act as one: every word closes a whole block
      write_size(CSR_ROWS, 0);
      write_size(CSR_COLS, 0);
      settings_used++;
      words_to_send.push_back('1);
      words_to_send.push_back('0);
      words_to_send.push_back(random_word());
      wait_idle();

      // half a block, then a rewrite of the same value abandons it
      write_size(CSR_ROWS, 2);
      write_size(CSR_COLS, 2);
      settings_used++;
      repeat (2) words_to_send.push_back(random_word());
      wait_idle();
      write_size(CSR_ROWS, 2);
      repeat (4) words_to_send.push_back(random_word());
      wait_idle();

      // random phases: mostly whole blocks, some cut short by the next size write
      random_words = 0;
      phase_no     = 0;
      while (random_words < RANDOM_WORDS) begin
         if (phase_no == 0) begin
            rows_val = 1;
            cols_val = 63;
         end else if (phase_no == 1) begin
            rows_val = 511;
            cols_val = 0;
         end else if ($urandom_range(0, 5) == 0) begin
            rows_val = $urandom_range(0, 2);
            cols_val = $urandom_range(24, 63);
         end else begin
            rows_val = $urandom_range(0, 5);
            cols_val = $urandom_range(0, 6);
         end
         if (phase_no > 1 && $urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) write_size(CSR_ROWS, rows_val);
            else write_size(CSR_COLS, cols_val);
         end else if ($urandom_range(0, 1) == 0) begin
            write_size(CSR_ROWS, rows_val);
            write_size(CSR_COLS, cols_val);
         end else begin
            write_size(CSR_COLS, cols_val);
            write_size(CSR_ROWS, rows_val);
         end
         block = eff_rows() * eff_cols();
         if (phase_no == 1) count = block + $urandom_range(1, 4);
         else count = $urandom_range(1, 3) * block;
         if (phase_no != 1 && block > 1 && $urandom_range(0, 3) == 0)
            count += $urandom_range(1, block - 1);
         // keep the total close to the planned word count
         if (count > RANDOM_WORDS - random_words) count = RANDOM_WORDS - random_words;
         repeat (count) words_to_send.push_back(random_word());
         random_words += count;
         settings_used++;
         phase_no++;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run sent %0d data words under %0d size settings, checked %0d coded words",
         words_sent, settings_used, words_checked);
      $display("of which %0d row parity, %0d column parity and %0d overall parity words",
         kind_seen[KIND_ROW], kind_seen[KIND_COL], kind_seen[KIND_ALL]);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/tdpe_pkg.sv
hdl/tdpe_if.sv
hdl/tdpe_cell.sv
hdl/two_d_parity_encoder.sv
tb/sv/two_d_parity_encoder_test.sv
